/* rtl/ncm_pkg.sv */
// Shared types and constants of the nearest colour matcher.
`default_nettype none

package ncm_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int INDEX_W = 5;
    localparam int HUE_W   = 9;
    localparam int SAT_W   = 7;
    localparam int BRI_W   = 7;
    localparam int NAME_W  = 8;
    localparam int LED_W   = 24;
    localparam int CLEAR_W = 16;

    localparam int COUNT_W   = 6;
    localparam int MAXD_W    = 16;
    localparam int MINCLR_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int HUE_ABS_W = 8;   // wrapped hue difference stays within 180
    localparam int HUE_SQ_W  = 2 * HUE_ABS_W;
    localparam int SAT_SQ_W  = 2 * SAT_W;
    localparam int BRI_SQ_W  = 2 * BRI_W;
    localparam int DIST_W    = 17;
    localparam int OUT_DIST_W = 16;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;
    localparam int STATUS_W   = 2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CLEAR   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_MATCH = 2'd0,
        STATUS_FAIL  = 2'd1,
        STATUS_FAR   = 2'd2
    } status_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [BRI_W-1:0] bri;
    } color_t;

    typedef struct packed {
        color_t            color;
        logic [NAME_W-1:0] name;
        logic [LED_W-1:0]  led;
    } entry_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] sq_dist;
        logic [NAME_W-1:0] name;
        logic [LED_W-1:0]  led;
    } dist_t;

endpackage

`default_nettype wire

/* rtl/ncm_dist.sv */
// Distance unit: wrapped hue difference and squared HSV distance of one entry per cycle.
`default_nettype none

module ncm_dist (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire ncm_pkg::entry_t in_entry,
    input  wire ncm_pkg::color_t query,
    output ncm_pkg::dist_t       result
);

    logic signed [10:0] hue_delta;
    logic signed [10:0] hue_wrap;
    logic [ncm_pkg::HUE_ABS_W-1:0] hue_abs;
    logic [ncm_pkg::SAT_W-1:0]     sat_abs;
    logic [ncm_pkg::BRI_W-1:0]     bri_abs;

    logic                          valid_reg;
    logic [ncm_pkg::HUE_SQ_W-1:0]  hue_sq_reg;
    logic [ncm_pkg::SAT_SQ_W-1:0]  sat_sq_reg;
    logic [ncm_pkg::BRI_SQ_W-1:0]  bri_sq_reg;
    logic [ncm_pkg::NAME_W-1:0]    name_reg;
    logic [ncm_pkg::LED_W-1:0]     led_reg;

    always_comb
    begin
        hue_delta = $signed({2'b00, in_entry.color.hue}) - $signed({2'b00, query.hue});
        // fold the difference into the half circle around zero
        if (hue_delta > 11'sd180)
        begin
            hue_wrap = hue_delta - 11'sd360;
        end
        else if (hue_delta < -11'sd180)
        begin
            hue_wrap = hue_delta + 11'sd360;
        end
        else
        begin
            hue_wrap = hue_delta;
        end
        hue_abs = (hue_wrap < 11'sd0) ? ncm_pkg::HUE_ABS_W'(-hue_wrap)
                                      : ncm_pkg::HUE_ABS_W'(hue_wrap);
        sat_abs = (in_entry.color.sat >= query.sat) ? in_entry.color.sat - query.sat
                                                    : query.sat - in_entry.color.sat;
        bri_abs = (in_entry.color.bri >= query.bri) ? in_entry.color.bri - query.bri
                                                    : query.bri - in_entry.color.bri;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_sq_reg <= ncm_pkg::HUE_SQ_W'(hue_abs) * ncm_pkg::HUE_SQ_W'(hue_abs);
        sat_sq_reg <= ncm_pkg::SAT_SQ_W'(sat_abs) * ncm_pkg::SAT_SQ_W'(sat_abs);
        bri_sq_reg <= ncm_pkg::BRI_SQ_W'(bri_abs) * ncm_pkg::BRI_SQ_W'(bri_abs);
        name_reg   <= in_entry.name;
        led_reg    <= in_entry.led;
    end

    always_comb
    begin
        result.valid   = valid_reg;
        result.sq_dist = ncm_pkg::DIST_W'(hue_sq_reg) + ncm_pkg::DIST_W'(sat_sq_reg)
                       + ncm_pkg::DIST_W'(bri_sq_reg);
        result.name    = name_reg;
        result.led     = led_reg;
    end

endmodule

`default_nettype wire

/* rtl/nearest_color_matcher.sv */
// Nearest colour matcher: colour table, scan sequencer and result register.
//
// Input stream (s_*): one word per item. s_tuser selects the kind: a write
// stores one table entry and gives no result, a query gives exactly one
// result word on the output stream (m_*).
// Configuration writes (cfg_*) set the entry count, the distance limit and
// the clear threshold; cfg_ready is always high. Write them while idle.
// A query that fails at once (empty table or too dark) goes straight to its
// result; otherwise the table is scanned one entry per cycle through the
// shared distance unit over the searched count of entries (entry_count,
// capped at 32), each read through the single table read port.
// s_tready is high only while the sequencer is idle. A finished result is
// held in the output register until m_tready takes it; meanwhile further
// writes are accepted, and a following query stalls only at its end.
// Reset clears the sequencer, the output valid and the registers to their
// defaults (count 0, limit 65535, clear threshold 0). Table contents are
// not cleared; entries must be written before they are searched.
`default_nettype none

module nearest_color_matcher (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [4:0] entry_index, [13:5] hue, [20:14] saturation, [27:21] brightness,
    // [35:28] name_code, [59:36] led_color, [75:60] clear_level, [79:76] zero
    input  wire logic [ncm_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] kind
    input  wire logic [0:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] match_name, [31:8] match_led, [47:32] match_distance
    output logic [ncm_pkg::OUT_DATA_W-1:0]         m_tdata,
    // [1:0] status
    output logic [ncm_pkg::STATUS_W-1:0]           m_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ncm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ncm_pkg::CFG_DAT_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [ncm_pkg::COUNT_W-1:0]  entry_count_reg;
    logic [ncm_pkg::MAXD_W-1:0]   max_distance_reg;
    logic [ncm_pkg::MINCLR_W-1:0] min_clear_reg;

    ncm_pkg::entry_t mem [ncm_pkg::TABLE_DEPTH];
    ncm_pkg::entry_t rd_data_reg;
    logic            rd_valid_reg;

    logic [ncm_pkg::INDEX_W-1:0] in_index;
    ncm_pkg::entry_t             in_entry;
    logic [ncm_pkg::CLEAR_W-1:0] in_clear;
    logic                        in_accept;

    ncm_pkg::color_t             query_reg;
    logic                        fail_reg;
    logic [ncm_pkg::CNT_W-1:0]   issue_cnt_reg;
    logic [ncm_pkg::CNT_W-1:0]   count_eff;
    logic                        rd_en;
    logic                        scan_done;

    ncm_pkg::dist_t              unit_out;
    logic                        have_best_reg;
    logic [ncm_pkg::DIST_W-1:0]  best_reg;
    logic [ncm_pkg::NAME_W-1:0]  best_name_reg;
    logic [ncm_pkg::LED_W-1:0]   best_led_reg;

    logic                        out_load;
    logic                        m_tvalid_reg;
    ncm_pkg::status_t            status_reg;
    logic [ncm_pkg::NAME_W-1:0]  out_name_reg;
    logic [ncm_pkg::LED_W-1:0]   out_led_reg;
    logic [ncm_pkg::OUT_DIST_W-1:0] out_dist_reg;

    // unpack the input word
    always_comb
    begin
        in_index        = s_tdata[4:0];
        in_entry.color.hue = s_tdata[13:5];
        in_entry.color.sat = s_tdata[20:14];
        in_entry.color.bri = s_tdata[27:21];
        in_entry.name   = s_tdata[35:28];
        in_entry.led    = s_tdata[59:36];
        in_clear        = s_tdata[75:60];
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign count_eff = (int'(entry_count_reg) > ncm_pkg::TABLE_DEPTH)
                     ? ncm_pkg::CNT_W'(ncm_pkg::TABLE_DEPTH)
                     : ncm_pkg::CNT_W'(entry_count_reg);

    assign rd_en     = (state_reg == ST_SCAN) && (issue_cnt_reg < count_eff);
    assign scan_done = (state_reg == ST_SCAN) && !rd_en && !rd_valid_reg && !unit_out.valid;
    assign out_load  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg  <= '0;
            max_distance_reg <= '1;
            min_clear_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ncm_pkg::CFG_ENTRY_COUNT:  entry_count_reg  <= cfg_data[ncm_pkg::COUNT_W-1:0];
                ncm_pkg::CFG_MAX_DISTANCE: max_distance_reg <= cfg_data[ncm_pkg::MAXD_W-1:0];
                ncm_pkg::CFG_MIN_CLEAR:    min_clear_reg    <= cfg_data[ncm_pkg::MINCLR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // colour table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (in_accept && (s_tuser[0] == ncm_pkg::KIND_WRITE)
            && (int'(in_index) < ncm_pkg::TABLE_DEPTH))
        begin
            mem[ncm_pkg::ADDR_W'(in_index)] <= in_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_cnt_reg[ncm_pkg::ADDR_W-1:0]];
        end
    end

    ncm_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .in_entry (rd_data_reg),
        .query    (query_reg),
        .result   (unit_out)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser[0] == ncm_pkg::KIND_QUERY))
                begin
                    if ((count_eff == '0) || (in_clear < ncm_pkg::CLEAR_W'(min_clear_reg)))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            issue_cnt_reg <= '0;
            have_best_reg <= 1'b0;
            fail_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
            if (in_accept && (s_tuser[0] == ncm_pkg::KIND_QUERY))
            begin
                issue_cnt_reg <= '0;
                have_best_reg <= 1'b0;
                fail_reg      <= (count_eff == '0)
                              || (in_clear < ncm_pkg::CLEAR_W'(min_clear_reg));
            end
            else
            begin
                if (rd_en)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (unit_out.valid)
                begin
                    have_best_reg <= 1'b1;
                end
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // running minimum; strict compare keeps the earliest entry on ties
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            query_reg <= in_entry.color;
        end
        if (unit_out.valid && (!have_best_reg || (unit_out.sq_dist < best_reg)))
        begin
            best_reg      <= unit_out.sq_dist;
            best_name_reg <= unit_out.name;
            best_led_reg  <= unit_out.led;
        end
        if (out_load)
        begin
            if (fail_reg)
            begin
                status_reg   <= ncm_pkg::STATUS_FAIL;
                out_name_reg <= '0;
                out_led_reg  <= '0;
                out_dist_reg <= '0;
            end
            else if (best_reg > ncm_pkg::DIST_W'(max_distance_reg))
            begin
                status_reg   <= ncm_pkg::STATUS_FAR;
                out_name_reg <= '0;
                out_led_reg  <= '0;
                out_dist_reg <= best_reg[ncm_pkg::OUT_DIST_W-1:0];
            end
            else
            begin
                status_reg   <= ncm_pkg::STATUS_MATCH;
                out_name_reg <= best_name_reg;
                out_led_reg  <= best_led_reg;
                out_dist_reg <= best_reg[ncm_pkg::OUT_DIST_W-1:0];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {out_dist_reg, out_led_reg, out_name_reg};

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking stream testbench for the nearest colour matcher.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ncm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 48;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 150;
    localparam int MAX_REPORTS    = 20;

    typedef struct packed {
        status_t                 status;
        logic [NAME_W-1:0]       name;
        logic [LED_W-1:0]        led;
        logic [OUT_DIST_W-1:0]   sq_dist;
    } match_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [0:0]             s_tuser = KIND_WRITE;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_ENTRY_COUNT;
    logic [CFG_DAT_W-1:0]   cfg_data = '0;

    // shadow of the block's table and registers
    entry_t shadow_table [TABLE_DEPTH];
    int     table_count = 0;
    int     table_max_dist = 65535;
    int     table_min_clear = 0;

    match_t pending_matches [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int n_writes = 0;
    int n_queries = 0;
    int status_seen [3] = '{0, 0, 0};

    nearest_color_matcher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic match_t predict_match(color_t probe, logic [CLEAR_W-1:0] clear);
        match_t res;
        int     span;
        int     hd;
        int     sd;
        int     bd;
        int     cur_dist;
        int     best;
        res.status  = STATUS_FAIL;
        res.name    = '0;
        res.led     = '0;
        res.sq_dist = '0;
        best = 0;
        span = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : table_count;
        if (span == 0 || int'(clear) < table_min_clear)
            return res;
        for (int i = 0; i < span; i++)
        begin
            hd = int'(shadow_table[i].color.hue) - int'(probe.hue);
            // wrap the hue difference onto the shorter way round the circle
            if (hd > 180)
                hd -= 360;
            if (hd < -180)
                hd += 360;
            sd = int'(shadow_table[i].color.sat) - int'(probe.sat);
            bd = int'(shadow_table[i].color.bri) - int'(probe.bri);
            cur_dist = hd * hd + sd * sd + bd * bd;
            // strict compare: the lowest slot keeps a tie
            if (i == 0 || cur_dist < best)
            begin
                best     = cur_dist;
                res.name = shadow_table[i].name;
                res.led  = shadow_table[i].led;
            end
        end
        res.sq_dist = best[OUT_DIST_W-1:0];
        if (best > table_max_dist)
        begin
            res.status = STATUS_FAR;
            res.name   = '0;
            res.led    = '0;
        end
        else
            res.status = STATUS_MATCH;
        return res;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        case (idx)
            CFG_ENTRY_COUNT:  table_count = int'(value[COUNT_W-1:0]);
            CFG_MAX_DISTANCE: table_max_dist = int'(value[MAXD_W-1:0]);
            CFG_MIN_CLEAR:    table_min_clear = int'(value[MINCLR_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic void take_item(logic kind, logic [IN_DATA_W-1:0] data);
        color_t c;
        c.hue = data[13:5];
        c.sat = data[20:14];
        c.bri = data[27:21];
        if (kind == KIND_WRITE)
        begin
            n_writes++;
            shadow_table[data[4:0]].color = c;
            shadow_table[data[4:0]].name  = data[35:28];
            shadow_table[data[4:0]].led   = data[59:36];
        end
        else
        begin
            n_queries++;
            pending_matches.push_back(predict_match(c, data[75:60]));
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < MAX_REPORTS)
            $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_result(logic [STATUS_W-1:0] status, logic [OUT_DATA_W-1:0] data);
        match_t want;
        if (pending_matches.size() == 0)
        begin
            report_mismatch("result word with no query pending, status", int'(status), -1);
            return;
        end
        want = pending_matches.pop_front();
        status_seen[int'(want.status)]++;
        if (status !== want.status)
            report_mismatch("status", int'(status), int'(want.status));
        if (data[7:0] !== want.name)
            report_mismatch("match_name", int'(data[7:0]), int'(want.name));
        if (data[31:8] !== want.led)
            report_mismatch("match_led", int'(data[31:8]), int'(want.led));
        if (data[47:32] !== want.sq_dist)
            report_mismatch("match_distance", int'(data[47:32]), int'(want.sq_dist));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                take_item(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
                check_result(m_tuser, m_tdata);
        end
    end

    // result side: random stalls, plus a long hold when one is requested
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= (int'($urandom_range(0, 99)) >= snk_idle_pct);
    end

    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: no word moved for %0d cycles, %0d queries pending",
                 quiet_cycles, pending_matches.size());
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    function automatic color_t hsv(int h, int s, int b);
        color_t c;
        c.hue = h[HUE_W-1:0];
        c.sat = s[SAT_W-1:0];
        c.bri = b[BRI_W-1:0];
        return c;
    endfunction

    function automatic color_t random_color();
        // mostly in range, now and then the full field width
        if ($urandom_range(0, 9) == 0)
            return hsv($urandom_range(0, 511), $urandom_range(0, 127), $urandom_range(0, 127));
        return hsv($urandom_range(0, 360), $urandom_range(0, 100), $urandom_range(0, 100));
    endfunction

    function automatic color_t near_color(int slot);
        int spread;
        int h;
        int s;
        int b;
        spread = ($urandom_range(0, 3) == 0) ? 0 : 12;
        h = int'(shadow_table[slot].color.hue) + int'($urandom_range(0, 2 * spread)) - spread;
        s = int'(shadow_table[slot].color.sat) + int'($urandom_range(0, 2 * spread)) - spread;
        b = int'(shadow_table[slot].color.bri) + int'($urandom_range(0, 2 * spread)) - spread;
        h = (h + 360) % 360;
        s = (s < 0) ? 0 : ((s > 127) ? 127 : s);
        b = (b < 0) ? 0 : ((b > 127) ? 127 : b);
        return hsv(h, s, b);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_item(logic [INDEX_W-1:0] slot, color_t c,
                                                       logic [NAME_W-1:0] name,
                                                       logic [LED_W-1:0] led,
                                                       logic [CLEAR_W-1:0] clear);
        return {4'b0, clear, led, name, c.bri, c.sat, c.hue, slot};
    endfunction

    // offer one word; s_tvalid stays high afterwards so the next word can follow at once
    task automatic push_item(logic kind, logic [IN_DATA_W-1:0] data);
        while (int'($urandom_range(0, 99)) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_write(logic [INDEX_W-1:0] slot, color_t c, logic [NAME_W-1:0] name,
                              logic [LED_W-1:0] led);
        push_item(KIND_WRITE, pack_item(slot, c, name, led, CLEAR_W'($urandom)));
    endtask

    task automatic send_query(color_t c, logic [CLEAR_W-1:0] clear);
        push_item(KIND_QUERY, pack_item(INDEX_W'($urandom), c, NAME_W'($urandom),
                                        LED_W'($urandom), clear));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // drop the input, drain the results, then let a trailing write finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(int count, int max_d, int min_c);
        // upper bits of the narrow registers carry junk that must be dropped
        write_reg(CFG_ENTRY_COUNT, {10'($urandom), 6'(count)});
        write_reg(CFG_MAX_DISTANCE, 16'(max_d));
        write_reg(CFG_MIN_CLEAR, {8'($urandom), 8'(min_c)});
    endtask

    task automatic run_traffic(int n_items);
        int span;
        color_t c;
        logic [CLEAR_W-1:0] clear;
        for (int n = 0; n < n_items; n++)
        begin
            span = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : table_count;
            if ($urandom_range(0, 99) < 75)
            begin
                if (span > 0 && $urandom_range(0, 9) < 7)
                    c = near_color($urandom_range(0, span - 1));
                else
                    c = random_color();
                if ($urandom_range(0, 4) == 0)
                    clear = CLEAR_W'($urandom_range(0, 300));
                else
                    clear = CLEAR_W'($urandom);
                send_query(c, clear);
            end
            else
                send_write(INDEX_W'($urandom), random_color(), NAME_W'($urandom),
                           LED_W'($urandom));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_empty_table();
        send_query(hsv(511, 127, 127), 16'hFFFF);
        send_query(hsv(0, 0, 0), 16'h0000);
        settle();
    endtask

    task automatic test_directed_search();
        send_write(5'd0, hsv(0, 0, 0), 8'h00, 24'h000000);
        send_write(5'd1, hsv(359, 100, 100), 8'hFF, 24'hFFFFFF);
        send_write(5'd2, hsv(180, 50, 50), 8'h5A, 24'hA5C3E1);
        // same colour as slot 1: slot 1 must win the tie
        send_write(5'd3, hsv(359, 100, 100), 8'h11, 24'h123456);
        settle();
        write_reg(CFG_ENTRY_COUNT, 16'hFFC4);
        send_query(hsv(0, 0, 0), 16'hFFFF);
        send_query(hsv(1, 100, 100), 16'hFFFF);
        send_query(hsv(180, 50, 50), 16'hFFFF);
        send_query(hsv(511, 127, 127), 16'hFFFF);
        send_query(hsv(90, 25, 25), 16'hFFFF);
        send_query(hsv(270, 75, 0), 16'hFFFF);
        settle();
    endtask

    task automatic test_register_limits();
        write_reg(CFG_MAX_DISTANCE, 16'd0);
        send_query(hsv(1, 0, 0), 16'hFFFF);
        send_query(hsv(180, 50, 50), 16'hFFFF);
        settle();
        write_reg(CFG_MAX_DISTANCE, 16'd4);
        send_query(hsv(1, 100, 100), 16'hFFFF);
        settle();
        write_reg(CFG_MAX_DISTANCE, 16'd3);
        send_query(hsv(1, 100, 100), 16'h8000);
        settle();
        write_reg(CFG_MAX_DISTANCE, 16'hFFFF);
        write_reg(CFG_MIN_CLEAR, 16'h3CC8);
        send_query(hsv(180, 50, 50), 16'd199);
        send_query(hsv(180, 50, 50), 16'd200);
        settle();
        // an index past the register list must change nothing
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_query(hsv(180, 50, 50), 16'd0);
        settle();
        write_reg(CFG_MIN_CLEAR, 16'h0000);
    endtask

    task automatic test_fill_table();
        int order [TABLE_DEPTH];
        int j;
        int t;
        for (int i = 0; i < TABLE_DEPTH; i++)
            order[i] = i;
        for (int i = TABLE_DEPTH - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_write(INDEX_W'(order[i]), random_color(), NAME_W'($urandom), LED_W'($urandom));
        settle();
    endtask

    task automatic test_random_phase(int phase);
        int count;
        int max_d;
        int min_c;
        case (phase)
            0:
            begin
                count = 32; max_d = 65535; min_c = 0;
            end
            1:
            begin
                count = 63; max_d = $urandom_range(0, 3000); min_c = $urandom_range(0, 255);
            end
            2:
            begin
                count = $urandom_range(1, 32); max_d = $urandom_range(0, 65535); min_c = 255;
            end
            3:
            begin
                count = 1; max_d = 0; min_c = 0;
            end
            4:
            begin
                count = 0; max_d = $urandom_range(0, 65535); min_c = $urandom_range(0, 255);
            end
            default:
            begin
                count = $urandom_range(1, 63);
                max_d = $urandom_range(0, 65535);
                min_c = $urandom_range(0, 255);
            end
        endcase
        set_regs(count, max_d, min_c);
        run_traffic(PHASE_ITEMS);
        settle();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_regs(32, 65535, 0);
        hold_requests <= hold_requests + 1;
        run_traffic(60);
        settle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_directed_search();
        test_register_limits();
        test_fill_table();
        for (int p = 0; p < 9; p++)
        begin
            case (p / 3)
                0:
                begin
                    src_idle_pct = 18; snk_idle_pct = 54;
                end
                1:
                begin
                    src_idle_pct = 54; snk_idle_pct = 18;
                end
                default:
                begin
                    src_idle_pct = 0; snk_idle_pct = 0;
                end
            endcase
            test_random_phase(p);
        end
        test_backpressure();

        $display("covered %0d table writes and %0d queries under three idling mixes",
                 n_writes, n_queries);
        $display("results: %0d matched, %0d too far, %0d empty or too dark; %0d mismatches",
                 status_seen[int'(STATUS_MATCH)], status_seen[int'(STATUS_FAR)],
                 status_seen[int'(STATUS_FAIL)], fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
